// ===== src/tfn_pkg.sv =====
// Shared constants for the triangle face normal block.
package tfn_pkg;
    localparam int NUM_AXES = 3;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;
endpackage

// ===== src/tfn_if.sv =====
// Handshake channels: triangle corners in, unit normal out.
interface tfn_tri_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] az;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic signed [W-1:0] bz;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] cz;
    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tfn_norm_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;
    logic                degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== src/triangle_face_normal.sv =====
// Top level: pipelined unit face normal of a triangle.
//
// i_tri carries the nine corner coordinates of one triangle per transfer;
// o_norm carries the unit normal (signed Q1.(NORMAL_WIDTH-2)) and a flag
// that is set, with a zero normal, when the cross product vanishes.
// Both channels transfer when valid and ready are high at a clock edge.
// Throughput is one triangle per cycle while o_norm does not stall. The stages
// from input transfer to output valid are edges, products, cross product,
// squares, setup, then one restoring square-root step per result bit
// (NORMAL_WIDTH steps), then the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken; while the receiver holds o_norm.ready low with a
// result waiting, every stage holds and i_tri.ready is low, so nothing is
// dropped or repeated. Synchronous reset (i_rst_n low) clears all valid
// bits; payload registers are not reset. The result is exact: each
// component is the integer nearest to N_i * 2^F / |N|, ties away from zero.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH  = 16,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tfn_tri_if.sink    i_tri,
    tfn_norm_if.source o_norm
);
    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_WIDTH - 2;
    localparam int EW  = CW + 1;
    localparam int PRW = 2 * CW + 2;
    localparam int MW  = 2 * CW + 1;
    localparam int QW  = 4 * CW + 2;
    localparam int SW  = 4 * CW + 4;
    localparam int TW  = QW + 2 * F + 2;
    localparam int QB  = F + 2;
    localparam int PW  = SW + QB;
    localparam int DW  = SW + 2 * F + 6;

    logic w_en;
    assign w_en        = !o_norm.valid || o_norm.ready;
    assign i_tri.ready = w_en;

    // Edges.
    logic              r_v1;
    logic signed [EW-1:0] r_e1 [NUM_AXES];
    logic signed [EW-1:0] r_e2 [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_tri.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1[AX_X] <= EW'(i_tri.bx) - EW'(i_tri.ax);
            r_e1[AX_Y] <= EW'(i_tri.by) - EW'(i_tri.ay);
            r_e1[AX_Z] <= EW'(i_tri.bz) - EW'(i_tri.az);
            r_e2[AX_X] <= EW'(i_tri.cx) - EW'(i_tri.ax);
            r_e2[AX_Y] <= EW'(i_tri.cy) - EW'(i_tri.ay);
            r_e2[AX_Z] <= EW'(i_tri.cz) - EW'(i_tri.az);
        end
    end

    // Six products of the cross product, one pair per axis.
    logic                  r_v2;
    logic signed [PRW-1:0] r_pa [NUM_AXES];
    logic signed [PRW-1:0] r_pb [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa[AX_X] <= PRW'(r_e1[AX_Y] * r_e2[AX_Z]);
            r_pb[AX_X] <= PRW'(r_e1[AX_Z] * r_e2[AX_Y]);
            r_pa[AX_Y] <= PRW'(r_e1[AX_Z] * r_e2[AX_X]);
            r_pb[AX_Y] <= PRW'(r_e1[AX_X] * r_e2[AX_Z]);
            r_pa[AX_Z] <= PRW'(r_e1[AX_X] * r_e2[AX_Y]);
            r_pb[AX_Z] <= PRW'(r_e1[AX_Y] * r_e2[AX_X]);
        end
    end

    // Cross product, split into magnitude and sign.
    logic          r_v3;
    logic [MW-1:0] r_mag [NUM_AXES];
    logic          r_neg3 [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_cross
        logic signed [PRW-1:0] d_n;
        logic        [PRW-1:0] d_abs;
        always_comb begin
            d_n   = r_pa[a] - r_pb[a];
            d_abs = d_n[PRW-1] ? PRW'(-d_n) : PRW'(d_n);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mag[a]  <= d_abs[MW-1:0];
                r_neg3[a] <= d_n[PRW-1];
            end
        end
    end

    // Squares of the components.
    logic          r_v4;
    logic [QW-1:0] r_sq [NUM_AXES];
    logic          r_neg4 [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_square
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[a]   <= QW'(r_mag[a] * r_mag[a]);
                r_neg4[a] <= r_neg3[a];
            end
        end
    end

    // Root stages. For each axis find the largest q with q^2 * s <= c^2 * 4^(F+1),
    // one bit per stage, keeping the remainder and p = q * s so that each step
    // needs only shifts, two adds, one compare and one subtract.
    logic          r_rv   [QB+1];
    logic [SW-1:0] r_s    [QB+1];
    logic          r_dg   [QB+1];
    logic [TW-1:0] r_rem  [QB+1][NUM_AXES];
    logic [PW-1:0] r_p    [QB+1][NUM_AXES];
    logic [QB-1:0] r_q    [QB+1][NUM_AXES];
    logic          r_sgn  [QB+1][NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (w_en) begin
            r_rv[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[0]  <= SW'(r_sq[AX_X]) + SW'(r_sq[AX_Y]) + SW'(r_sq[AX_Z]);
            r_dg[0] <= (r_sq[AX_X] == '0) && (r_sq[AX_Y] == '0) && (r_sq[AX_Z] == '0);
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_setup
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[0][a] <= {r_sq[a], {(2 * F + 2){1'b0}}};
                r_p[0][a]   <= '0;
                r_q[0][a]   <= '0;
                r_sgn[0][a] <= r_neg4[a];
            end
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_root
        localparam int J = QB - 1 - g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[g+1] <= 1'b0;
            end else if (w_en) begin
                r_rv[g+1] <= r_rv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s[g+1]  <= r_s[g];
                r_dg[g+1] <= r_dg[g];
            end
        end

        for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
            logic [DW-1:0] d_delta;
            logic [DW-1:0] d_rem;
            logic          d_fit;
            always_comb begin
                d_delta = (DW'(r_p[g][a]) << (J + 1)) + (DW'(r_s[g]) << (2 * J));
                d_rem   = DW'(r_rem[g][a]);
                d_fit   = d_delta <= d_rem;
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[g+1][a] <= d_fit ? TW'(d_rem - d_delta) : r_rem[g][a];
                    r_p[g+1][a]   <= d_fit ? PW'(DW'(r_p[g][a]) + (DW'(r_s[g]) << J))
                                           : r_p[g][a];
                    r_q[g+1][a]   <= r_q[g][a] | (QB'(d_fit) << J);
                    r_sgn[g+1][a] <= r_sgn[g][a];
                end
            end
        end
    end

    // Output register: the largest odd k <= q gives m = (q + 1) / 2.
    logic                          r_ov;
    logic signed [NORMAL_WIDTH-1:0] r_nrm [NUM_AXES];
    logic                          r_odg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_rv[QB];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_out
        logic [QB:0]             d_inc;
        logic [NORMAL_WIDTH-1:0] d_m;
        always_comb begin
            d_inc = {1'b0, r_q[QB][a]} + (QB + 1)'(1);
            d_m   = NORMAL_WIDTH'(d_inc[QB:1]);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_dg[QB]) begin
                    r_nrm[a] <= '0;
                end else begin
                    r_nrm[a] <= r_sgn[QB][a] ? $signed(-d_m) : $signed(d_m);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odg <= r_dg[QB];
        end
    end

    assign o_norm.valid      = r_ov;
    assign o_norm.normal_x   = r_nrm[AX_X];
    assign o_norm.normal_y   = r_nrm[AX_Y];
    assign o_norm.normal_z   = r_nrm[AX_Z];
    assign o_norm.degenerate = r_odg;

    localparam logic signed [NORMAL_WIDTH-1:0] ONE = NORMAL_WIDTH'(1) << F;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_norm.valid && o_norm.degenerate) |->
        (o_norm.normal_x == '0 && o_norm.normal_y == '0 && o_norm.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_norm.valid && !o_norm.degenerate) |->
        (o_norm.normal_x != '0 || o_norm.normal_y != '0 || o_norm.normal_z != '0))
        else $error("nondegenerate result with zero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_norm.valid |->
        (o_norm.normal_x <= ONE && o_norm.normal_x >= -ONE &&
         o_norm.normal_y <= ONE && o_norm.normal_y >= -ONE &&
         o_norm.normal_z <= ONE && o_norm.normal_z >= -ONE))
        else $error("normal component beyond unit range");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tri.valid && i_tri.ready) |=> r_v1)
        else $error("accepted transfer lost at first stage");
endmodule

// ===== sim/tb.sv =====
// Testbench for triangle_face_normal: directed and random triangles, exact normal predictor.
`timescale 1ns / 100ps

module tb;
    import tfn_pkg::*;

    localparam int CW = 16;
    localparam int NW = 16;
    localparam int FRAC = NW - 2;
    localparam int LATENCY = NW + 6;

    typedef struct {
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } t_corners;

    typedef struct {
        logic signed [NW-1:0] nx, ny, nz;
        logic                 degen;
    } t_unit_normal;

    logic i_clk;
    logic i_rst_n;

    tfn_tri_if  #(.W(CW)) corners_ch ();
    tfn_norm_if #(.W(NW)) normal_ch ();

    triangle_face_normal #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (corners_ch),
        .o_norm  (normal_ch)
    );

    t_unit_normal expected_normals[$];
    int  error_count = 0;
    int  tri_count = 0;
    int  degen_seen = 0;
    int  normals_seen = 0;
    bit  calm = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: timeout with %0d results outstanding", expected_normals.size());
        $display("tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Largest m with (2m-1)^2 * s <= (|c| * 2^(F+1))^2, i.e. |c|*2^F/sqrt(s) rounded.
    function automatic logic signed [NW-1:0] scaled_component(longint c, logic [127:0] s);
        logic [127:0] mag;
        logic [127:0] t;
        logic [127:0] lhs;
        logic [127:0] k;
        longint lo;
        longint hi;
        longint mid;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        t = mag << (FRAC + 1);
        t = t * t;
        lo = 0;
        hi = longint'(1) << FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            k = 128'(2 * mid - 1);
            lhs = k * k * s;
            if (lhs <= t) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? NW'(-lo) : NW'(lo);
    endfunction

    function automatic t_unit_normal face_normal(t_corners p);
        t_unit_normal r;
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        longint cx, cy, cz;
        logic signed [127:0] wx, wy, wz;
        logic [127:0] s;
        e1x = longint'(p.bx) - longint'(p.ax);
        e1y = longint'(p.by) - longint'(p.ay);
        e1z = longint'(p.bz) - longint'(p.az);
        e2x = longint'(p.cx) - longint'(p.ax);
        e2y = longint'(p.cy) - longint'(p.ay);
        e2z = longint'(p.cz) - longint'(p.az);
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        wx = cx;
        wy = cy;
        wz = cz;
        s = wx * wx + wy * wy + wz * wz;
        if (s == 0) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.degen = 1'b1;
        end else begin
            r.nx = scaled_component(cx, s);
            r.ny = scaled_component(cy, s);
            r.nz = scaled_component(cz, s);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_triangle(t_corners p);
        if (!calm && $urandom_range(99) < 38) begin
            corners_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 38);
        end
        corners_ch.valid <= 1'b1;
        corners_ch.ax <= p.ax; corners_ch.ay <= p.ay; corners_ch.az <= p.az;
        corners_ch.bx <= p.bx; corners_ch.by <= p.by; corners_ch.bz <= p.bz;
        corners_ch.cx <= p.cx; corners_ch.cy <= p.cy; corners_ch.cz <= p.cz;
        do @(posedge i_clk); while (!corners_ch.ready);
        expected_normals.push_back(face_normal(p));
        tri_count++;
    endtask

    function automatic t_corners make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz);
        t_corners p;
        p.ax = CW'(ax); p.ay = CW'(ay); p.az = CW'(az);
        p.bx = CW'(bx); p.by = CW'(by); p.bz = CW'(bz);
        p.cx = CW'(cx); p.cy = CW'(cy); p.cz = CW'(cz);
        return p;
    endfunction

    function automatic t_corners random_full();
        return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    endfunction

    // Small triangle around a random point, the usual case for meshes.
    function automatic t_corners random_small();
        int ox, oy, oz, r;
        ox = $urandom_range(60000) - 30000;
        oy = $urandom_range(60000) - 30000;
        oz = $urandom_range(60000) - 30000;
        r = (1 << $urandom_range(10)) + 1;
        return make_tri(ox, oy, oz,
                        ox + $urandom_range(2 * r) - r, oy + $urandom_range(2 * r) - r,
                        oz + $urandom_range(2 * r) - r,
                        ox + $urandom_range(2 * r) - r, oy + $urandom_range(2 * r) - r,
                        oz + $urandom_range(2 * r) - r);
    endfunction

    // Collinear or coincident corners: the cross product vanishes.
    function automatic t_corners random_degenerate();
        int ax, ay, az, dx, dy, dz, k1, k2;
        ax = $urandom_range(16000) - 8000;
        ay = $urandom_range(16000) - 8000;
        az = $urandom_range(16000) - 8000;
        dx = $urandom_range(2000) - 1000;
        dy = $urandom_range(2000) - 1000;
        dz = $urandom_range(2000) - 1000;
        k1 = $urandom_range(10) - 5;
        k2 = $urandom_range(10) - 5;
        return make_tri(ax, ay, az, ax + k1 * dx, ay + k1 * dy, az + k1 * dz,
                        ax + k2 * dx, ay + k2 * dy, az + k2 * dz);
    endfunction

    task automatic test_directed();
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(100, 200, 300, 100, 200, 300, 100, 200, 300));
        send_triangle(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                               -32768, -32768, -32768));
        // Axis-aligned normals give full-scale components of both signs.
        send_triangle(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
        send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        send_triangle(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
        send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // Largest edges in every direction.
        send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                               -32768, 32767, -32768));
        send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                               32767, 32767, -32768));
        send_triangle(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                               32767, 32767, -32768));
        send_triangle(make_tri(32767, -32768, 32767, -32768, 32767, 32767,
                               -32768, -32768, -32768));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1));
        send_triangle(make_tri(0, 0, 0, 32767, 1, 0, -32768, 0, 1));
        send_triangle(make_tri(-1, -1, -1, 0, 0, 0, 5, -3, 7));
    endtask

    task automatic test_random_mix(int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 50) send_triangle(random_full());
            else if (sel < 85) send_triangle(random_small());
            else send_triangle(random_degenerate());
        end
    endtask

    task automatic test_degenerate(int count);
        for (int i = 0; i < count; i++) send_triangle(random_degenerate());
    endtask

    task automatic test_back_to_back(int count);
        calm = 1;
        for (int i = 0; i < count; i++) send_triangle(random_full());
        calm = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            normal_ch.ready <= 1'b0;
        end else begin
            normal_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    always @(posedge i_clk) begin
        t_unit_normal want;
        if (i_rst_n && normal_ch.valid && normal_ch.ready) begin
            normals_seen++;
            if (normal_ch.degenerate) degen_seen++;
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_normals.pop_front();
                if (normal_ch.normal_x !== want.nx)
                    report_mismatch("normal_x", normal_ch.normal_x, want.nx);
                if (normal_ch.normal_y !== want.ny)
                    report_mismatch("normal_y", normal_ch.normal_y, want.ny);
                if (normal_ch.normal_z !== want.nz)
                    report_mismatch("normal_z", normal_ch.normal_z, want.nz);
                if (normal_ch.degenerate !== want.degen)
                    report_mismatch("degenerate", normal_ch.degenerate, want.degen);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        normal_ch.ready = 1'b0;
        corners_ch.valid = 1'b0;
        {corners_ch.ax, corners_ch.ay, corners_ch.az} = '0;
        {corners_ch.bx, corners_ch.by, corners_ch.bz} = '0;
        {corners_ch.cx, corners_ch.cy, corners_ch.cz} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(300);
        test_degenerate(40);
        test_back_to_back(100);
        test_random_mix(30);
        corners_ch.valid <= 1'b0;

        while (expected_normals.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (expected_normals.size() != 0)
            report_mismatch("results left over", expected_normals.size(), 0);

        $display("tb: %0d triangles sent, %0d normals checked, %0d flagged degenerate",
                 tri_count, normals_seen, degen_seen);
        $display("tb: covered extreme corners, axis normals, collinear sets, random stalls");
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/tfn_pkg.sv
src/tfn_if.sv
src/triangle_face_normal.sv
sim/tb.sv
